>>> rtl/wfq_pkg.sv
// Package for the windowed fault qualifier.
// Holds channel count, field widths, register index codes and reset values.
// No dependencies.
package wfq_pkg;

  localparam int CHANNELS = 4;

  localparam int CHAN_W   = 2;
  localparam int WIN_W    = 8;
  localparam int STOP_W   = 4;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [WIN_W-1:0]  win_t;
  typedef logic [STOP_W-1:0] stop_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_STOP_LIMIT    = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_t;

  localparam win_t  WINDOW_LENGTH_RST = 8'd3;
  localparam stop_t STOP_LIMIT_RST    = 4'd3;
  localparam stop_t STOP_MAX          = 4'd15;

endpackage

>>> rtl/windowed_fault_qualifier.sv
// An accepted item passes through the input register, then the result
// register. Throughput: one item per cycle while out_ready takes results;
// each item does a single read-modify-write of its channel's counters
// in the cycle it leaves the input register.
// Reset (rst_n low, synchronous) disarms all channels, clears all counters
// and the fault latch, empties both registers and restores the config.
// Top level of the windowed fault qualifier; depends on wfq_pkg.
module windowed_fault_qualifier (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  wfq_pkg::chan_t               in_channel,
  input  logic                         in_sample_open,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_sample_used,
  output logic                         out_channel_armed,
  output wfq_pkg::stop_t               out_stop_count_now,
  output logic                         out_fault_latched,
  output wfq_pkg::chan_t               out_fault_source,
  input  logic                         cfg_wr_en,
  input  logic [wfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfq_pkg::CFG_W-1:0]    cfg_wdata
);
  import wfq_pkg::*;

  // Configuration.
  win_t  window_length_r;
  stop_t stop_limit_r;

  // Input register.
  logic  s1_valid_r;
  logic  s1_req_r;
  chan_t s1_chan_r;
  logic  s1_open_r;

  // Channel state.
  logic  [CHANNELS-1:0] armed_r,        armed_nxt;
  win_t  window_count_r [CHANNELS],     window_count_nxt [CHANNELS];
  win_t  open_count_r   [CHANNELS],     open_count_nxt   [CHANNELS];
  stop_t stop_count_r   [CHANNELS],     stop_count_nxt   [CHANNELS];
  logic  fault_flag_r,    fault_flag_nxt;
  chan_t fault_channel_r, fault_channel_nxt;

  // Result register.
  logic  out_valid_r;
  logic  out_used_r, out_used_nxt;
  logic  out_armed_r, out_armed_nxt;
  stop_t out_stop_r, out_stop_nxt;

  logic  adv;
  logic  chan_ok;
  win_t  wc_inc;
  win_t  oc_inc;
  logic  win_end;
  logic  majority;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign chan_ok  = int'(s1_chan_r) < CHANNELS;

  assign wc_inc   = window_count_r[s1_chan_r] + win_t'(1);
  assign oc_inc   = open_count_r[s1_chan_r] + win_t'(s1_open_r);
  assign win_end  = wc_inc >= window_length_r;
  assign majority = {oc_inc, 1'b0} > {1'b0, window_length_r};

  always_comb begin
    armed_nxt         = armed_r;
    window_count_nxt  = window_count_r;
    open_count_nxt    = open_count_r;
    stop_count_nxt    = stop_count_r;
    fault_flag_nxt    = fault_flag_r;
    fault_channel_nxt = fault_channel_r;
    out_used_nxt      = 1'b0;
    if (chan_ok) begin
      if (s1_req_r == REQ_CLEAR) begin
        armed_nxt[s1_chan_r]        = 1'b0;
        window_count_nxt[s1_chan_r] = '0;
        open_count_nxt[s1_chan_r]   = '0;
        stop_count_nxt[s1_chan_r]   = '0;
      end else if (fault_flag_r && fault_channel_r != s1_chan_r) begin
        // Another channel owns the latched fault; the sample is dropped.
      end else if (!s1_open_r && !armed_r[s1_chan_r]) begin
        // Closed sample on an idle channel.
      end else if (stop_count_r[s1_chan_r] >= stop_limit_r) begin
        fault_flag_nxt    = 1'b1;
        fault_channel_nxt = s1_chan_r;
      end else begin
        out_used_nxt = 1'b1;
        if (s1_open_r) begin
          armed_nxt[s1_chan_r] = 1'b1;
        end
        window_count_nxt[s1_chan_r] = wc_inc;
        open_count_nxt[s1_chan_r]   = oc_inc;
        if (win_end) begin
          if (majority) begin
            if (stop_count_r[s1_chan_r] < STOP_MAX) begin
              stop_count_nxt[s1_chan_r] = stop_count_r[s1_chan_r] + stop_t'(1);
            end
          end else begin
            stop_count_nxt[s1_chan_r] = '0;
            armed_nxt[s1_chan_r]      = 1'b0;
          end
          window_count_nxt[s1_chan_r] = '0;
          open_count_nxt[s1_chan_r]   = '0;
        end
      end
    end
    out_armed_nxt = chan_ok ? armed_nxt[s1_chan_r] : 1'b0;
    out_stop_nxt  = chan_ok ? stop_count_nxt[s1_chan_r] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_LENGTH_RST;
      stop_limit_r    <= STOP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_LENGTH: window_length_r <= cfg_wdata[WIN_W-1:0];
        CFG_STOP_LIMIT:    stop_limit_r    <= cfg_wdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r  <= in_req_type;
      s1_chan_r <= in_channel;
      s1_open_r <= in_sample_open;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r         <= '0;
      fault_flag_r    <= 1'b0;
      fault_channel_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        window_count_r[i] <= '0;
        open_count_r[i]   <= '0;
        stop_count_r[i]   <= '0;
      end
    end else if (adv) begin
      armed_r          <= armed_nxt;
      window_count_r   <= window_count_nxt;
      open_count_r     <= open_count_nxt;
      stop_count_r     <= stop_count_nxt;
      fault_flag_r     <= fault_flag_nxt;
      fault_channel_r  <= fault_channel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_used_r  <= out_used_nxt;
      out_armed_r <= out_armed_nxt;
      out_stop_r  <= out_stop_nxt;
    end
  end

  // The fault fields show the latch as it stands after the item in the
  // result register; nothing else changes the latch until the next item.
  assign out_valid          = out_valid_r;
  assign out_sample_used    = out_used_r;
  assign out_channel_armed  = out_armed_r;
  assign out_stop_count_now = out_stop_r;
  assign out_fault_latched  = fault_flag_r;
  assign out_fault_source   = fault_channel_r;

  // A disarmed channel always has a cleared stop count.
  logic disarm_stop_ok;
  always_comb begin
    disarm_stop_ok = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!armed_r[i] && stop_count_r[i] != '0) begin
        disarm_stop_ok = 1'b0;
      end
    end
  end

  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fault_flag_r |=> fault_flag_r)
    else $error("fault latch dropped without reset");

  a_fault_rise_on_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fault_flag_r) |-> $past(adv))
    else $error("fault latch set without a processed item");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed item left no result");

  a_disarm_stop: assert property (@(posedge clk) disable iff (!rst_n)
    disarm_stop_ok)
    else $error("disarmed channel holds a stop count");

endmodule

>>> tb/windowed_fault_qualifier_test.sv
// Self-checking testbench for windowed_fault_qualifier.
// Drives directed and random requests through valid/ready and checks each result
// against an in-bench model or a fixed expected value. Depends on wfq_pkg and the RTL top.
module windowed_fault_qualifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wfq_pkg::*;

  typedef struct packed {
    logic  used;
    logic  armed;
    stop_t stop;
    logic  flt;
    chan_t src;
  } qual_result_t;

  typedef struct {
    bit           is_cfg;
    cfg_idx_t     idx;
    win_t         val;
    req_t         req;
    chan_t        ch;
    logic         open;
    bit           typed;
    qual_result_t res;
  } plan_row_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic           in_req_type = 1'b0;
  chan_t          in_channel = '0;
  logic           in_sample_open = 1'b0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic           out_sample_used;
  logic           out_channel_armed;
  stop_t          out_stop_count_now;
  logic           out_fault_latched;
  chan_t          out_fault_source;
  logic           cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Model state of the qualifier.
  logic  ch_armed [CHANNELS] = '{default: 1'b0};
  win_t  win_cnt  [CHANNELS] = '{default: '0};
  win_t  open_cnt [CHANNELS] = '{default: '0};
  stop_t stop_cnt [CHANNELS] = '{default: '0};
  logic  flt_flag = 1'b0;
  chan_t flt_chan = '0;
  win_t  win_len  = WINDOW_LENGTH_RST;
  stop_t stop_lim = STOP_LIMIT_RST;

  qual_result_t pending_results [$];
  plan_row_t    plan_rows [$];

  int mismatch_cnt = 0;
  int n_items = 0;
  int n_used = 0;
  int n_windows = 0;
  int n_fault_hits = 0;
  int n_settings = 0;
  int burst_left = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_tick = 0;

  windowed_fault_qualifier u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_channel         (in_channel),
    .in_sample_open     (in_sample_open),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_used    (out_sample_used),
    .out_channel_armed  (out_channel_armed),
    .out_stop_count_now (out_stop_count_now),
    .out_fault_latched  (out_fault_latched),
    .out_fault_source   (out_fault_source),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advances the model by one accepted item and returns the result it predicts.
  function automatic qual_result_t qualify_step(input req_t r, input chan_t c, input logic o);
    qual_result_t res;
    res = '0;
    if (r == REQ_CLEAR) begin
      ch_armed[c] = 1'b0;
      win_cnt[c]  = '0;
      open_cnt[c] = '0;
      stop_cnt[c] = '0;
    end else if (flt_flag && flt_chan != c) begin
      // Another channel owns the fault, so this sample is dropped.
    end else if (!o && !ch_armed[c]) begin
      // Closed sample on an idle channel.
    end else if (stop_cnt[c] >= stop_lim) begin
      flt_flag = 1'b1;
      flt_chan = c;
      n_fault_hits++;
    end else begin
      res.used = 1'b1;
      if (o) begin
        ch_armed[c] = 1'b1;
        open_cnt[c] = open_cnt[c] + 1'b1;
      end
      win_cnt[c] = win_cnt[c] + 1'b1;
      if (win_cnt[c] >= win_len) begin
        n_windows++;
        if (int'(open_cnt[c]) * 2 > int'(win_len)) begin
          if (stop_cnt[c] < STOP_MAX) stop_cnt[c] = stop_cnt[c] + 1'b1;
        end else begin
          stop_cnt[c] = '0;
          ch_armed[c] = 1'b0;
        end
        win_cnt[c]  = '0;
        open_cnt[c] = '0;
      end
    end
    res.armed = ch_armed[c];
    res.stop  = stop_cnt[c];
    res.flt   = flt_flag;
    res.src   = flt_chan;
    return res;
  endfunction

  task automatic add_row(input bit is_cfg, input cfg_idx_t idx, input win_t val, input req_t r,
                         input chan_t c, input logic o, input bit typed, input qual_result_t res);
    plan_row_t row;
    row.is_cfg = is_cfg;
    row.idx    = idx;
    row.val    = val;
    row.req    = r;
    row.ch     = c;
    row.open   = o;
    row.typed  = typed;
    row.res    = res;
    plan_rows.push_back(row);
  endtask

  // Offers one item, holds it until accepted, then records what should come back.
  task automatic offer_item(input req_t r, input chan_t c, input logic o, input bit typed,
                            input qual_result_t typed_res, output qual_result_t res);
    int gap;
    in_valid       <= 1'b1;
    in_req_type    <= r;
    in_channel     <= c;
    in_sample_open <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = qualify_step(r, c, o);
    pending_results.push_back(typed ? typed_res : res);
    n_items++;
    if (res.used) n_used++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input win_t val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_WINDOW_LENGTH) win_len = val;
    else stop_lim = val[STOP_W-1:0];
    n_settings++;
  endtask

  task automatic run_rows(input int lo, input int hi);
    qual_result_t res;
    for (int i = lo; i < hi; i++) begin
      if (plan_rows[i].is_cfg) begin
        write_reg(plan_rows[i].idx, plan_rows[i].val);
      end else begin
        offer_item(plan_rows[i].req, plan_rows[i].ch, plan_rows[i].open, plan_rows[i].typed,
                   plan_rows[i].res, res);
      end
    end
  endtask

  // Mostly window-shaped runs of samples on one focus channel with an open bias that
  // is redrawn at each window start, plus clears and stray samples on any channel.
  // With keep_clear set, a sample that would latch the fault is turned into a clear.
  task automatic run_random(input int quota, input bit keep_clear, input int switch_pct);
    int effective;
    int tries;
    int pick;
    int bias;
    chan_t focus;
    req_t r;
    chan_t c;
    logic o;
    qual_result_t res;
    effective = 0;
    tries = 0;
    bias = 50;
    focus = flt_flag ? flt_chan : chan_t'($urandom_range(0, CHANNELS - 1));
    hold_seq <= hold_seq + 1;
    while (effective < quota && tries < 3 * quota) begin
      tries++;
      if ($urandom_range(0, 99) < switch_pct) focus = chan_t'($urandom_range(0, CHANNELS - 1));
      if (win_cnt[focus] == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 10;
          1:       bias = 50;
          default: bias = 90;
        endcase
      end
      pick = $urandom_range(0, 99);
      r = REQ_SAMPLE;
      c = focus;
      o = ($urandom_range(0, 99) < bias);
      if (pick < 5) begin
        r = REQ_CLEAR;
        c = chan_t'($urandom_range(0, CHANNELS - 1));
      end else if (pick < 15) begin
        c = chan_t'($urandom_range(0, CHANNELS - 1));
        o = 1'($urandom_range(0, 1));
      end
      if (keep_clear && r == REQ_SAMPLE && stop_cnt[c] >= stop_lim) r = REQ_CLEAR;
      offer_item(r, c, o, 1'b0, '0, res);
      if (res.used || r == REQ_CLEAR) effective++;
    end
  endtask

  // Result side: checks each accepted result, then picks the next ready value.
  always @(posedge clk) begin
    qual_result_t got;
    qual_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_sample_used, out_channel_armed, out_stop_count_now, out_fault_latched,
             out_fault_source};
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("%0t: result with nothing pending: used %0d armed %0d stop %0d flt %0d src %0d",
                   $realtime, got.used, got.armed, got.stop, got.flt, got.src);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: expected used %0d armed %0d stop %0d flt %0d src %0d", $realtime,
                     want.used, want.armed, want.stop, want.flt, want.src);
            $display("%0t:      got used %0d armed %0d stop %0d flt %0d src %0d", $realtime,
                     got.used, got.armed, got.stop, got.flt, got.src);
          end
          mismatch_cnt++;
        end
      end
    end
    rx_tick++;
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 64);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (rx_tick % 4 == 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    int fault_first;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: window of 3, limit of 3.
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 0, 0, 1, {1'b0, 1'b0, 4'd0, 1'b0, 2'd0});
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_CLEAR,  3, 1, 1, {1'b0, 1'b0, 4'd0, 1'b0, 2'd0});
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 0, 1, 1, {1'b1, 1'b1, 4'd0, 1'b0, 2'd0});
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 0, 1, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 0, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 1, 1, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 1, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 1, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 1, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_CLEAR,  0, 0, 1, {1'b0, 1'b0, 4'd0, 1'b0, 2'd0});
    add_row(1, CFG_WINDOW_LENGTH, 8'd255, REQ_SAMPLE, 0, 0, 0, '0);
    add_row(1, CFG_STOP_LIMIT,    8'd15,  REQ_SAMPLE, 0, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 2, 1, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 3, 1, 0, '0);
    // A zero-length window judges on every used sample.
    add_row(1, CFG_WINDOW_LENGTH, 8'd0, REQ_SAMPLE, 0, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 2, 1, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 2, 0, 0, '0);
    add_row(1, CFG_WINDOW_LENGTH, 8'd1, REQ_SAMPLE, 0, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 3, 0, 0, '0);
    // The fault latch only clears on reset, so these rows run after the fault-free phases.
    fault_first = plan_rows.size();
    add_row(1, CFG_STOP_LIMIT, 8'd0, REQ_SAMPLE, 0, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 1, 1, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 2, 1, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_CLEAR,  1, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 1, 0, 0, '0);
    add_row(1, CFG_STOP_LIMIT, 8'd2, REQ_SAMPLE, 0, 0, 0, '0);
    add_row(0, CFG_WINDOW_LENGTH, 0, REQ_SAMPLE, 1, 1, 0, '0);

    run_rows(0, fault_first);

    write_reg(CFG_WINDOW_LENGTH, 8'd1);
    write_reg(CFG_STOP_LIMIT, 8'd1);
    run_random(50, 1'b1, 10);
    write_reg(CFG_WINDOW_LENGTH, 8'd2);
    write_reg(CFG_STOP_LIMIT, 8'd4);
    run_random(50, 1'b1, 10);
    write_reg(CFG_WINDOW_LENGTH, 8'd5);
    write_reg(CFG_STOP_LIMIT, 8'd15);
    run_random(50, 1'b1, 8);
    write_reg(CFG_WINDOW_LENGTH, 8'd4);
    write_reg(CFG_STOP_LIMIT, 8'd2);
    run_random(50, 1'b1, 10);
    write_reg(CFG_WINDOW_LENGTH, 8'd0);
    write_reg(CFG_STOP_LIMIT, 8'd5);
    run_random(40, 1'b1, 10);
    // One long window: keep one focus channel throughout the run.
    write_reg(CFG_WINDOW_LENGTH, 8'd255);
    write_reg(CFG_STOP_LIMIT, 8'd1);
    run_random(260, 1'b1, 0);

    run_rows(fault_first, plan_rows.size());
    write_reg(CFG_WINDOW_LENGTH, 8'd3);
    run_random(30, 1'b0, 5);

    settle();
    repeat (4) @(posedge clk);
    $display("Covered %0d items over %0d register writes: %0d samples used, %0d windows judged,",
             n_items, n_settings, n_used, n_windows);
    $display("%0d fault hits; %0d mismatches.", n_fault_hits, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still pending.", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/wfq_pkg.sv
rtl/windowed_fault_qualifier.sv
tb/windowed_fault_qualifier_test.sv
